FILE: rtl/body_euler_step_wall_bounce_core_macros.svh
// Assertion macros shared by the body step RTL.
// No dependencies; include by bare file name inside a module.
`ifndef BODY_EULER_STEP_WALL_BOUNCE_CORE_MACROS_SVH
`define BODY_EULER_STEP_WALL_BOUNCE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BEWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bews check failed");

// next-cycle implication, disabled during reset
`define BEWS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bews check failed");

`endif

FILE: rtl/bews_pkg.sv
// Shared types, constants and fixed point helpers for the body step core.
// No dependencies.
package bews_pkg;

  localparam logic [4:0] FRAC_BITS  = 5'd16;
  localparam logic [4:0] ELAST_BITS = 5'd16;
  localparam int DIV_BITS = 33;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef enum logic [2:0] {
    REG_GRAVITY     = 3'd0,
    REG_TIME_STEP   = 3'd1,
    REG_WALL_TOP    = 3'd2,
    REG_WALL_BOTTOM = 3'd3,
    REG_WALL_LEFT   = 3'd4,
    REG_WALL_RIGHT  = 3'd5
  } bews_reg_t;

  // body data carried alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [16:0]        e;
    logic [2:0]         neg;
    logic [2:0]         ovf;
  } bews_side_t;

  // clamp to the 32 bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7fffffff;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [65:0] tz_shift(input logic signed [65:0] p,
                                                  input logic [4:0] sh);
    logic signed [65:0] bias;
    bias = (p < 0) ? ((66'sd1 <<< sh) - 66'sd1) : 66'sd0;
    return (p + bias) >>> sh;
  endfunction

  function automatic logic signed [65:0] abs66(input logic signed [65:0] p);
    return (p < 0) ? -p : p;
  endfunction

endpackage

FILE: rtl/bews_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on bews_pkg.
module bews_div (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] divisor,
  input  logic [30:0] rem_in,
  input  logic [bews_pkg::DIV_BITS-1:0] num_lo,
  output logic [bews_pkg::DIV_BITS-1:0] quot
);
  import bews_pkg::*;

  logic [30:0]         r_st  [DIV_BITS];
  logic [DIV_BITS-1:0] lo_st [DIV_BITS];
  logic [DIV_BITS-1:0] q_st  [DIV_BITS];
  logic [30:0]         m_st  [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [30:0]         rp;
    logic [DIV_BITS-1:0] lp;
    logic [DIV_BITS-1:0] qp;
    logic [30:0]         mp;
    logic [31:0]         t;
    logic                ge;

    if (k == 0) begin : g_first
      assign rp = rem_in;
      assign lp = num_lo;
      assign qp = '0;
      assign mp = divisor;
    end else begin : g_next
      assign rp = r_st[k-1];
      assign lp = lo_st[k-1];
      assign qp = q_st[k-1];
      assign mp = m_st[k-1];
    end

    // shift in the next numerator bit and try the subtraction
    assign t  = {rp, lp[DIV_BITS-1]};
    assign ge = t >= {1'b0, mp};

    always_ff @(posedge clk) begin
      if (en) begin
        r_st[k]  <= ge ? 31'(t - {1'b0, mp}) : t[30:0];
        lo_st[k] <= {lp[DIV_BITS-2:0], 1'b0};
        q_st[k]  <= {qp[DIV_BITS-2:0], ge};
        m_st[k]  <= mp;
      end
    end
  end

  assign quot = q_st[DIV_BITS-1];

endmodule

FILE: rtl/body_euler_step_wall_bounce_core.sv
// Body step core: one body word in per cycle. The length of the pipeline is
// set by the 33 stage divider that forms force*time_step/mass in each lane,
// plus five front and seven back stages; an unaccepted output word freezes the
// whole pipeline, so throughput is one body per cycle while the sink keeps up.
// Depends on bews_pkg, bews_div and the shared assertion macros.
module body_euler_step_wall_bounce_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z,
  // body_mass(31), restitution(17)
  input  logic [335:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output logic [191:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bews_pkg::*;
  `include "body_euler_step_wall_bounce_core_macros.svh"

  // configuration registers
  logic signed [31:0] gravity, wall_top, wall_bottom, wall_left, wall_right;
  logic [30:0]        time_step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity     <= 32'sd0;
      time_step   <= 31'd0;
      wall_top    <= 32'sd5242880;
      wall_bottom <= -32'sd5242880;
      wall_left   <= -32'sd7864320;
      wall_right  <= 32'sd7864320;
    end else if (psel && penable && pwrite) begin
      case (bews_reg_t'(paddr[4:2]))
        REG_GRAVITY:     gravity     <= pwdata;
        REG_TIME_STEP:   time_step   <= pwdata[30:0];
        REG_WALL_TOP:    wall_top    <= pwdata;
        REG_WALL_BOTTOM: wall_bottom <= pwdata;
        REG_WALL_LEFT:   wall_left   <= pwdata;
        REG_WALL_RIGHT:  wall_right  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bews_reg_t'(paddr[4:2]))
      REG_GRAVITY:     prdata = gravity;
      REG_TIME_STEP:   prdata = {1'b0, time_step};
      REG_WALL_TOP:    prdata = wall_top;
      REG_WALL_BOTTOM: prdata = wall_bottom;
      REG_WALL_LEFT:   prdata = wall_left;
      REG_WALL_RIGHT:  prdata = wall_right;
      default:         prdata = 32'd0;
    endcase
  end

  // advance the whole pipe unless the output word is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [31:0] dt_s;
  assign dt_s = $signed({1'b0, time_step});

  // unpack input word
  logic signed [31:0] in_fx, in_fy, in_fz;
  logic [30:0]        in_m;
  assign in_fx = s_tdata[223:192];
  assign in_fy = s_tdata[255:224];
  assign in_fz = s_tdata[287:256];
  assign in_m  = s_tdata[318:288];

  // stage 1: weight and x/z impulse products
  logic               v1;
  bews_side_t         sd1;
  logic signed [31:0] fy1;
  logic [30:0]        m1;
  logic signed [63:0] gm1, pfx1, pfz1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd1.px  <= s_tdata[31:0];
      sd1.py  <= s_tdata[63:32];
      sd1.pz  <= s_tdata[95:64];
      sd1.vx  <= s_tdata[127:96];
      sd1.vy  <= s_tdata[159:128];
      sd1.vz  <= s_tdata[191:160];
      sd1.e   <= s_tdata[335:319];
      sd1.neg <= '0;
      sd1.ovf <= '0;
      fy1     <= in_fy;
      m1      <= in_m;
      gm1     <= gravity * $signed({1'b0, in_m});
      pfx1    <= in_fx * dt_s;
      pfz1    <= in_fz * dt_s;
    end
  end

  // stage 2: subtract weight from y force
  logic               v2;
  bews_side_t         sd2;
  logic signed [31:0] fy2;
  logic [30:0]        m2;
  logic signed [63:0] pfx2, pfz2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd2  <= sd1;
      fy2  <= sat32(66'(fy1) - 66'(sat32(tz_shift(66'(gm1), FRAC_BITS))));
      m2   <= m1;
      pfx2 <= pfx1;
      pfz2 <= pfz1;
    end
  end

  // stage 3: y impulse product
  logic               v3;
  bews_side_t         sd3;
  logic [30:0]        m3;
  logic signed [63:0] pfx3, pfy3, pfz3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd3  <= sd2;
      m3   <= m2;
      pfx3 <= pfx2;
      pfy3 <= fy2 * dt_s;
      pfz3 <= pfz2;
    end
  end

  // stage 4: split impulses into sign and magnitude, clamp zero mass
  logic        v4;
  bews_side_t  sd4, sd4_next;
  logic [30:0] m4;
  logic [63:0] mag4 [3];

  always_comb begin
    sd4_next     = sd3;
    sd4_next.neg = {pfz3 < 0, pfy3 < 0, pfx3 < 0};
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd4     <= sd4_next;
      m4      <= (m3 == 31'd0) ? 31'd1 : m3;
      mag4[0] <= (pfx3 < 0) ? 64'(-pfx3) : 64'(pfx3);
      mag4[1] <= (pfy3 < 0) ? 64'(-pfy3) : 64'(pfy3);
      mag4[2] <= (pfz3 < 0) ? 64'(-pfz3) : 64'(pfz3);
    end
  end

  // stage 5: flag quotients too large for the divider
  logic        v5;
  bews_side_t  sd5, sd5_next;
  logic [30:0] m5;
  logic [63:0] mag5 [3];

  always_comb begin
    sd5_next     = sd4;
    sd5_next.ovf = {mag4[2] >= {m4, 33'd0}, mag4[1] >= {m4, 33'd0},
                    mag4[0] >= {m4, 33'd0}};
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd5  <= sd5_next;
      m5   <= m4;
      mag5 <= mag4;
    end
  end

  // divider lanes and matching side line
  logic [DIV_BITS-1:0] quot [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    bews_div u_div (
      .clk     (clk),
      .en      (en),
      .divisor (m5),
      .rem_in  ({2'b00, mag5[i][61:33]}),
      .num_lo  (mag5[i][32:0]),
      .quot    (quot[i])
    );
  end

  logic       vd  [DIV_BITS];
  bews_side_t sdd [DIV_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_BITS; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= v5;
      for (int k = 1; k < DIV_BITS; k++) vd[k] <= vd[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sdd[0] <= sd5;
      for (int k = 1; k < DIV_BITS; k++) sdd[k] <= sdd[k-1];
    end
  end

  // stage 6: add signed quotients to velocity
  logic       v6;
  bews_side_t sd6, sdq, sd6_next;
  logic signed [65:0] qs [3];
  logic [33:0]        qm [3];

  assign sdq = sdd[DIV_BITS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i] = sdq.ovf[i] ? 34'h2_0000_0000 : {1'b0, quot[i]};
      qs[i] = sdq.neg[i] ? -$signed(66'(qm[i])) : $signed(66'(qm[i]));
    end
  end

  always_comb begin
    sd6_next    = sdq;
    sd6_next.vx = sat32(66'(sdq.vx) + qs[0]);
    sd6_next.vy = sat32(66'(sdq.vy) + qs[1]);
    sd6_next.vz = sat32(66'(sdq.vz) + qs[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= vd[DIV_BITS-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd6 <= sd6_next;
    end
  end

  // stage 7: elasticity products for top and left walls
  logic               v7;
  bews_side_t         sd7;
  logic signed [49:0] pex7, pey7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd7  <= sd6;
      pex7 <= sd6.vx * $signed({1'b0, sd6.e});
      pey7 <= sd6.vy * $signed({1'b0, sd6.e});
    end
  end

  // stage 8: reflect at top and left walls
  logic               v8;
  bews_side_t         sd8, sd8_next;
  logic signed [65:0] ex7, ey7;

  assign ex7 = abs66(tz_shift(66'(pex7), ELAST_BITS));
  assign ey7 = abs66(tz_shift(66'(pey7), ELAST_BITS));

  always_comb begin
    sd8_next    = sd7;
    sd8_next.vy = (sd7.py > wall_top) ? sat32(-ey7) : sd7.vy;
    sd8_next.vx = (sd7.px < wall_left) ? sat32(ex7) : sd7.vx;
  end

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd8 <= sd8_next;
    end
  end

  // stage 9: elasticity products for bottom and right walls
  logic               v9;
  bews_side_t         sd9;
  logic signed [49:0] pex9, pey9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd9  <= sd8;
      pex9 <= sd8.vx * $signed({1'b0, sd8.e});
      pey9 <= sd8.vy * $signed({1'b0, sd8.e});
    end
  end

  // stage 10: reflect at bottom and right walls
  logic               v10;
  bews_side_t         sd10, sd10_next;
  logic signed [65:0] ex9, ey9;

  assign ex9 = abs66(tz_shift(66'(pex9), ELAST_BITS));
  assign ey9 = abs66(tz_shift(66'(pey9), ELAST_BITS));

  always_comb begin
    sd10_next    = sd9;
    sd10_next.vy = (sd9.py < wall_bottom) ? sat32(ey9) : sd9.vy;
    sd10_next.vx = (sd9.px > wall_right) ? sat32(-ex9) : sd9.vx;
  end

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd10 <= sd10_next;
    end
  end

  // stage 11: displacement products
  logic               v11;
  bews_side_t         sd11;
  logic signed [63:0] dx11, dy11, dz11;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd11 <= sd10;
      dx11 <= sd10.vx * dt_s;
      dy11 <= sd10.vy * dt_s;
      dz11 <= sd10.vz * dt_s;
    end
  end

  // stage 12: advance position into the output word
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[31:0]    <= sat32(66'(sd11.px) +
                                66'(sat32(tz_shift(66'(dx11), FRAC_BITS))));
      m_tdata[63:32]   <= sat32(66'(sd11.py) +
                                66'(sat32(tz_shift(66'(dy11), FRAC_BITS))));
      m_tdata[95:64]   <= sat32(66'(sd11.pz) +
                                66'(sat32(tz_shift(66'(dz11), FRAC_BITS))));
      m_tdata[127:96]  <= sd11.vx;
      m_tdata[159:128] <= sd11.vy;
      m_tdata[191:160] <= sd11.vz;
    end
  end

  // checks on stall control and wall reflection
  `BEWS_ASSERT_IMP(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  `BEWS_ASSERT_NXT(a_accept_enters, clk, rst, s_tvalid && s_tready, v1)
  `BEWS_ASSERT_IMP(a_top_down, clk, rst, v8 && (sd8.py > wall_top), sd8.vy <= 0)
  `BEWS_ASSERT_IMP(a_right_left, clk, rst, v10 && (sd10.px > wall_right), sd10.vx <= 0)

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the body step core: streams bodies, predicts each
// updated position and velocity, and compares them with the core's output.
// Depends on bews_pkg and body_euler_step_wall_bounce_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bews_pkg::*;

  localparam int LATENCY = 45;
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_RANDOM = 750;

  typedef struct packed {
    logic [16:0] rest;
    logic [30:0] mass;
    logic signed [31:0] fz, fy, fx, vz, vy, vx, pz, py, px;
  } body_t;

  typedef struct packed {
    logic signed [31:0] vz, vy, vx, pz, py, px;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z,
  // body_mass(31), restitution(17)
  logic [335:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  logic [191:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  body_euler_step_wall_bounce_core i_dut (.*);

  always #1 clk = ~clk;

  // predictor copy of the registers
  logic signed [31:0] grav_r, top_r, bot_r, left_r, right_r;
  logic [30:0] dt_r;

  body_t pending_bodies[$];
  step_t expected_steps[$];
  int errors = 0;
  int steps_seen = 0;
  int idle_cycles = 0;
  int gap_in = 0;
  int gap_out = 0;
  bit timed_out = 1'b0;

  // append a body to the pending list
  function automatic void add_body(body_t b);
    pending_bodies.insert(pending_bodies.size(), b);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product of two Q16.16 values, truncated toward zero, clamped
  function automatic longint qprod(longint a, longint b);
    return clamp32((a * b) / 65536);
  endfunction

  function automatic longint bounce_mag(longint v, longint e);
    longint p;
    p = (v * e) / 65536;
    return p < 0 ? -p : p;
  endfunction

  function automatic step_t euler_step(body_t b);
    longint m, e, dt, fy, vx, vy, vz;
    step_t r;
    m = longint'(b.mass);
    e = longint'(b.rest);
    dt = longint'(dt_r);
    fy = clamp32(longint'(b.fy) - qprod(grav_r, m));
    if (m == 0) m = 1;
    vx = clamp32(longint'(b.vx) + (longint'(b.fx) * dt) / m);
    vy = clamp32(longint'(b.vy) + (fy * dt) / m);
    vz = clamp32(longint'(b.vz) + (longint'(b.fz) * dt) / m);
    if (b.py > top_r) vy = clamp32(-bounce_mag(vy, e));
    if (b.py < bot_r) vy = clamp32(bounce_mag(vy, e));
    if (b.px < left_r) vx = clamp32(bounce_mag(vx, e));
    if (b.px > right_r) vx = clamp32(-bounce_mag(vx, e));
    r.px = 32'(clamp32(longint'(b.px) + qprod(vx, dt)));
    r.py = 32'(clamp32(longint'(b.py) + qprod(vy, dt)));
    r.pz = 32'(clamp32(longint'(b.pz) + qprod(vz, dt)));
    r.vx = 32'(vx);
    r.vy = 32'(vy);
    r.vz = 32'(vz);
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at word %0d: %s got %h expected %h", steps_seen, what, got, want);
    errors++;
  endtask

  // driver: present pending bodies with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        s_tvalid <= 1'b0;
      end else if (pending_bodies.size() > 0) begin
        s_tdata <= {pending_bodies[0].rest, pending_bodies[0].mass,
                    pending_bodies[0].fz, pending_bodies[0].fy, pending_bodies[0].fx,
                    pending_bodies[0].vz, pending_bodies[0].vy, pending_bodies[0].vx,
                    pending_bodies[0].pz, pending_bodies[0].py, pending_bodies[0].px};
        expected_steps.insert(expected_steps.size(),
                              euler_step(pending_bodies.pop_front()));
        s_tvalid <= 1'b1;
        gap_in <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: stall the output at random and check each word
  always @(posedge clk) begin
    step_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        steps_seen++;
        if (expected_steps.size() == 0) begin
          $display("unexpected output word %h", m_tdata);
          errors++;
        end else begin
          want = expected_steps.pop_front();
          if (got.px !== want.px) report_mismatch("new_pos_x", got.px, want.px);
          if (got.py !== want.py) report_mismatch("new_pos_y", got.py, want.py);
          if (got.pz !== want.pz) report_mismatch("new_pos_z", got.pz, want.pz);
          if (got.vx !== want.vx) report_mismatch("new_vel_x", got.vx, want.vx);
          if (got.vy !== want.vy) report_mismatch("new_vel_y", got.vy, want.vy);
          if (got.vz !== want.vz) report_mismatch("new_vel_z", got.vz, want.vz);
        end
      end
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        gap_out <= pick_gap();
      end
    end
  end

  // watchdog on cycles with no accepted word and no register access
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
  end

  task automatic write_reg(bews_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRAVITY: grav_r = val;
      REG_TIME_STEP: dt_r = val[30:0];
      REG_WALL_TOP: top_r = val;
      REG_WALL_BOTTOM: bot_r = val;
      REG_WALL_LEFT: left_r = val;
      default: right_r = val;
    endcase
  endtask

  task automatic drain();
    while ((pending_bodies.size() > 0 || expected_steps.size() > 0) && !timed_out)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h00ffffff);
      3: return -$urandom_range(0, 32'h00ffffff);
      default: return $urandom;
    endcase
  endfunction

  // body with modest values near the walls, the usual case
  function automatic body_t plain_body();
    body_t b;
    b = '0;
    b.px = $signed($urandom_range(0, 32'h01400000)) - 32'sh00a00000;
    b.py = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    b.pz = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
    b.vx = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    b.vy = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    b.vz = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    b.fx = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    b.fy = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    b.fz = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    b.mass = 31'($urandom_range(1, 32'h00100000));
    b.rest = 17'($urandom_range(0, 65536));
    return b;
  endfunction

  function automatic body_t wild_body();
    body_t b;
    b.px = rand_word(); b.py = rand_word(); b.pz = rand_word();
    b.vx = rand_word(); b.vy = rand_word(); b.vz = rand_word();
    b.fx = rand_word(); b.fy = rand_word(); b.fz = rand_word();
    b.mass = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 3)) : 31'($urandom);
    b.rest = 17'($urandom_range(0, 131071));
    return b;
  endfunction

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) add_body(wild_body());
      else add_body(plain_body());
    end
    drain();
  endtask

  initial begin
    body_t b;
    grav_r = '0; dt_r = '0;
    top_r = 32'sd5242880; bot_r = -32'sd5242880;
    left_r = -32'sd7864320; right_r = 32'sd7864320;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, then a typical step with gravity
    add_body(plain_body());
    drain();
    write_reg(REG_GRAVITY, 32'hfff6_3000);
    write_reg(REG_TIME_STEP, 32'h0000_0444);
    // each wall, restitution zero, one, and above one, zero mass, extremes
    b = plain_body(); b.py = 32'sh00600000; b.rest = 17'd65536; add_body(b);
    b = plain_body(); b.py = -32'sh00600000; b.rest = 17'd0; add_body(b);
    b = plain_body(); b.px = -32'sh00800000; b.rest = 17'h1ffff; add_body(b);
    b = plain_body(); b.px = 32'sh00800000; b.rest = 17'd32768; add_body(b);
    b = plain_body(); b.py = 32'sd5242880; b.px = 32'sd7864320; add_body(b);
    b = plain_body(); b.mass = 31'd0; add_body(b);
    b = '1; b.rest = 17'h1ffff; add_body(b);
    b = '0; add_body(b);
    b = {17'h1ffff, 31'h7fffffff, {9{32'h7fffffff}}}; add_body(b);
    b = {17'h10000, 31'd1, {9{32'h80000000}}}; add_body(b);
    b = {17'h10000, 31'd1, {3{32'h7fffffff}}, {6{32'h80000000}}}; add_body(b);
    drain();
    random_phase(150);

    // extreme settings: largest step and gravity, walls at the range ends
    write_reg(REG_GRAVITY, 32'h7fffffff);
    write_reg(REG_TIME_STEP, 32'h7fffffff);
    write_reg(REG_WALL_TOP, 32'h7fffffff);
    write_reg(REG_WALL_BOTTOM, 32'h80000000);
    write_reg(REG_WALL_LEFT, 32'h80000000);
    write_reg(REG_WALL_RIGHT, 32'h7fffffff);
    random_phase(150);

    // crossed walls so both tests of an axis fire
    write_reg(REG_GRAVITY, 32'h80000000);
    write_reg(REG_TIME_STEP, 32'h0000_1000);
    write_reg(REG_WALL_TOP, 32'hff80_0000);
    write_reg(REG_WALL_BOTTOM, 32'h0080_0000);
    write_reg(REG_WALL_LEFT, 32'h0080_0000);
    write_reg(REG_WALL_RIGHT, 32'hff80_0000);
    random_phase(150);

    // zero step, then random settings
    write_reg(REG_TIME_STEP, 32'h0);
    write_reg(REG_GRAVITY, 32'h0);
    random_phase(50);
    repeat (3) begin
      write_reg(REG_GRAVITY, rand_word());
      write_reg(REG_TIME_STEP, $urandom_range(0, 32'h0002_0000));
      write_reg(REG_WALL_TOP, 32'h0050_0000 + $urandom_range(0, 32'h0010_0000));
      write_reg(REG_WALL_BOTTOM, -32'sh0050_0000 - $urandom_range(0, 32'h0010_0000));
      write_reg(REG_WALL_LEFT, -32'sh0050_0000 - $urandom_range(0, 32'h0010_0000));
      write_reg(REG_WALL_RIGHT, rand_word());
      random_phase(85);
    end

    $display("covered %0d output words over reset, extreme, crossed-wall and random settings",
             steps_seen);
    if (timed_out) begin
      $display("testbench failed");
    end else if (errors == 0 && expected_steps.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
